>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check macros for the index mapper RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// condition holds on every clock edge out of reset
`define CHK_ALWAYS(label, clk, rst, cond) \
  `CHK_IMPL(label, clk, rst, 1'b1, cond)

`endif

>>> hw/rtl/idxmap_pkg.sv
// ----------------------------------------------------------------------------
// idxmap_pkg
// Types and constants shared by the distributed index mapper.
// ----------------------------------------------------------------------------
package idxmap_pkg;

  localparam int IDX_W      = 48;
  localparam int OFF_W      = IDX_W + 1;
  localparam int LOC_W      = 32;
  localparam int RANK_W     = 16;
  localparam int CNT_W      = 17;
  localparam int BW_W       = 31;
  localparam int CW_W       = 24;
  localparam int PROD_W     = CNT_W + CW_W;
  localparam int HALF_W     = IDX_W / 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic OP_L2G = 1'b0;
  localparam logic OP_G2L = 1'b1;

  typedef enum logic [2:0] {
    MODE_DUP     = 3'd0,
    MODE_BLOCK   = 3'd1,
    MODE_CYCLIC  = 3'd2,
    MODE_BCYCLIC = 3'd3,
    MODE_GBLOCK  = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIST_MODE    = 3'd0,
    REG_GLOBAL_BASE  = 3'd1,
    REG_NODE_RANK    = 3'd2,
    REG_NODE_COUNT   = 3'd3,
    REG_BLOCK_WIDTH  = 3'd4,
    REG_CYCLE_WIDTH  = 3'd5,
    REG_GBLOCK_START = 3'd6
  } reg_idx_t;

  // per-item data that rides along the divider
  typedef struct packed {
    logic             opcode;
    logic [IDX_W-1:0] idx;
    logic [OFF_W-1:0] off;
    logic             neg_a;
    logic             neg_b;
  } side_t;

  // configuration as seen by the back end, zero counts already mapped to one
  typedef struct packed {
    logic [2:0]        mode;
    logic [IDX_W-1:0]  base;
    logic [IDX_W-1:0]  gstart;
    logic [RANK_W-1:0] rank;
    logic [CNT_W-1:0]  size;
    logic [BW_W-1:0]   bw;
    logic [CW_W-1:0]   w;
  } cfg_t;

endpackage

>>> hw/rtl/idxmap_div.sv
// ----------------------------------------------------------------------------
// idxmap_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module idxmap_div
  import idxmap_pkg::*;
#(
  parameter int N  = 49,
  parameter int D  = 41,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [N-1:0]  num,
  input  logic [D-1:0]  den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [N-1:0]  quo,
  output logic [D-1:0]  rem,
  output logic [SW-1:0] side_out
);

  logic [N-1:0]  vld;
  logic [N-1:0]  rq [N];
  logic [D-1:0]  pr [N];
  logic [D-1:0]  dv [N];
  logic [SW-1:0] sd [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic          v_in;
    logic [N-1:0]  rq_in;
    logic [D-1:0]  pr_in;
    logic [D-1:0]  dv_in;
    logic [SW-1:0] sd_in;
    logic [D:0]    trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_in  = in_valid;
      assign rq_in = num;
      assign pr_in = '0;
      assign dv_in = den;
      assign sd_in = side_in;
    end else begin : g_rest
      assign v_in  = vld[i-1];
      assign rq_in = rq[i-1];
      assign pr_in = pr[i-1];
      assign dv_in = dv[i-1];
      assign sd_in = sd[i-1];
    end

    assign trial = {pr_in, rq_in[N-1]};
    assign ge    = (trial >= {1'b0, dv_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rq[i] <= {rq_in[N-2:0], ge};
        pr[i] <= ge ? D'(trial - {1'b0, dv_in}) : trial[D-1:0];
        dv[i] <= dv_in;
        sd[i] <= sd_in;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign quo       = rq[N-1];
  assign rem       = pr[N-1];
  assign side_out  = sd[N-1];

endmodule

>>> hw/rtl/idxmap_post.sv
// ----------------------------------------------------------------------------
// idxmap_post
// Sign fixup, multiply and final per-mode sum, ending in the output register.
// ----------------------------------------------------------------------------
module idxmap_post
  import idxmap_pkg::*;
#(
  parameter int GLOBAL_WIDTH = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [OFF_W-1:0]  quo,
  input  logic [PROD_W-1:0] rem_a,
  input  logic [CW_W-1:0]   rem_b,
  input  side_t             side,
  input  cfg_t              cfg,
  output logic              out_valid,
  output logic [IDX_W-1:0]  index_out,
  output logic              mode_error
);

  // stage 0: signs back on
  logic [OFF_W-1:0] qs;
  logic [IDX_W-1:0] ra, rs;
  logic [LOC_W-1:0] rbu, rbs;

  assign qs  = side.neg_a ? -quo : quo;
  assign ra  = {{(IDX_W-PROD_W){1'b0}}, rem_a};
  assign rs  = side.neg_a ? -ra : ra;
  assign rbu = {{(LOC_W-CW_W){1'b0}}, rem_b};
  assign rbs = side.neg_b ? -rbu : rbu;

  logic             p0_valid;
  side_t            p0_side;
  logic [LOC_W-1:0] p0_q, p0_rbs;
  logic [IDX_W-1:0] p0_rs, p0_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else if (en) begin
      p0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_side <= side;
      p0_q    <= qs[LOC_W-1:0];
      p0_rbs  <= rbs;
      p0_rs   <= rs;
      p0_x    <= side.idx - rs;
    end
  end

  // stage 1: products
  logic [PROD_W-1:0]      lo_full, hi_full;
  logic [RANK_W+BW_W-1:0] rb_full;
  logic [RANK_W+CW_W-1:0] rw_full;
  logic [LOC_W+CW_W-1:0]  qw_full;

  assign lo_full = p0_x[HALF_W-1:0] * cfg.size;
  assign hi_full = p0_x[IDX_W-1:HALF_W] * cfg.size;
  assign rb_full = cfg.rank * cfg.bw;
  assign rw_full = cfg.rank * cfg.w;
  assign qw_full = p0_q * cfg.w;

  logic                   p1_valid;
  side_t                  p1_side;
  logic [PROD_W-1:0]      p1_lo;
  logic [HALF_W-1:0]      p1_hi;
  logic [RANK_W+BW_W-1:0] p1_rb;
  logic [RANK_W+CW_W-1:0] p1_rw;
  logic [LOC_W-1:0]       p1_qw, p1_q, p1_rbs;
  logic [IDX_W-1:0]       p1_rs;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= p0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_side <= p0_side;
      p1_lo   <= lo_full;
      p1_hi   <= hi_full[HALF_W-1:0];
      p1_rb   <= rb_full;
      p1_rw   <= rw_full;
      p1_qw   <= qw_full[LOC_W-1:0];
      p1_q    <= p0_q;
      p1_rbs  <= p0_rbs;
      p1_rs   <= p0_rs;
    end
  end

  // stage 2: recombine the split product
  logic                   p2_valid;
  side_t                  p2_side;
  logic [IDX_W-1:0]       p2_m, p2_rs;
  logic [RANK_W+BW_W-1:0] p2_rb;
  logic [RANK_W+CW_W-1:0] p2_rw;
  logic [LOC_W-1:0]       p2_qw, p2_q, p2_rbs;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_side <= p1_side;
      p2_m    <= {{(IDX_W-PROD_W){1'b0}}, p1_lo} + {p1_hi, {HALF_W{1'b0}}};
      p2_rs   <= p1_rs;
      p2_rb   <= p1_rb;
      p2_rw   <= p1_rw;
      p2_qw   <= p1_qw;
      p2_q    <= p1_q;
      p2_rbs  <= p1_rbs;
    end
  end

  // stage 3: per-mode sum into the output register
  logic [IDX_W-1:0] rb48, rw48, rank48, l2g, l2g_fin, res;
  logic [LOC_W-1:0] g2l;
  logic             err;

  assign rb48   = {{(IDX_W-RANK_W-BW_W){1'b0}}, p2_rb};
  assign rw48   = {{(IDX_W-RANK_W-CW_W){1'b0}}, p2_rw};
  assign rank48 = {{(IDX_W-RANK_W){1'b0}}, cfg.rank};

  always_comb begin
    l2g = '0;
    g2l = '0;
    err = 1'b0;
    unique case (cfg.mode)
      MODE_DUP: begin
        l2g = cfg.base + p2_side.idx;
        g2l = p2_side.off[LOC_W-1:0];
      end
      MODE_BLOCK: begin
        l2g = cfg.base + rb48 + p2_side.idx;
        g2l = p2_side.off[LOC_W-1:0] - rb48[LOC_W-1:0];
      end
      MODE_CYCLIC: begin
        l2g = cfg.base + rank48 + p2_m;
        g2l = p2_q;
      end
      MODE_BCYCLIC: begin
        l2g = cfg.base + rw48 + p2_m + p2_rs;
        g2l = p2_qw + p2_rbs;
      end
      MODE_GBLOCK: begin
        l2g = p2_side.idx + cfg.gstart;
        g2l = p2_side.idx[LOC_W-1:0] - cfg.gstart[LOC_W-1:0];
      end
      default: begin
        err = 1'b1;
      end
    endcase
  end

  if (GLOBAL_WIDTH >= IDX_W) begin : g_wide
    assign l2g_fin = l2g;
  end else begin : g_narrow
    assign l2g_fin = {{(IDX_W-GLOBAL_WIDTH){l2g[GLOBAL_WIDTH-1]}}, l2g[GLOBAL_WIDTH-1:0]};
  end

  always_comb begin
    if (err) begin
      res = '0;
    end else if (p2_side.opcode == OP_G2L) begin
      res = {{(IDX_W-LOC_W){g2l[LOC_W-1]}}, g2l};
    end else begin
      res = l2g_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      index_out  <= res;
      mode_error <= err;
    end
  end

endmodule

>>> hw/rtl/distributed_index_mapper.sv
// Throughput: one item per cycle while the output is not stalled.
// The 49-stage bit-per-stage divider sets the pipeline depth.
// A stalled output freezes the whole pipeline, bubbles included.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
// distributed_index_mapper
// Local/global index conversion for block, cyclic and related distributions.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module distributed_index_mapper
  import idxmap_pkg::*;
#(
  parameter int GLOBAL_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic signed [IDX_W-1:0] index_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [IDX_W-1:0] index_out,
  output logic                  mode_error,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [2:0]        dist_mode;
  logic [IDX_W-1:0]  global_base, gblock_start;
  logic [RANK_W-1:0] node_rank;
  logic [CNT_W-1:0]  node_count;
  logic [BW_W-1:0]   block_width;
  logic [CW_W-1:0]   cycle_width;
  logic [PROD_W-1:0] ws_prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_mode    <= MODE_DUP;
      global_base  <= '0;
      node_rank    <= '0;
      node_count   <= CNT_W'(1);
      block_width  <= BW_W'(1);
      cycle_width  <= CW_W'(1);
      gblock_start <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DIST_MODE:    dist_mode    <= cfg_data[2:0];
        REG_GLOBAL_BASE:  global_base  <= cfg_data[IDX_W-1:0];
        REG_NODE_RANK:    node_rank    <= cfg_data[RANK_W-1:0];
        REG_NODE_COUNT:   node_count   <= cfg_data[CNT_W-1:0];
        REG_BLOCK_WIDTH:  block_width  <= cfg_data[BW_W-1:0];
        REG_CYCLE_WIDTH:  cycle_width  <= cfg_data[CW_W-1:0];
        REG_GBLOCK_START: gblock_start <= cfg_data[IDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cfg_t cfg;

  assign cfg.mode   = dist_mode;
  assign cfg.base   = global_base;
  assign cfg.gstart = gblock_start;
  assign cfg.rank   = node_rank;
  assign cfg.size   = (node_count == '0) ? CNT_W'(1) : node_count;
  assign cfg.bw     = block_width;
  assign cfg.w      = (cycle_width == '0) ? CW_W'(1) : cycle_width;

  // block-cyclic span, size * width
  always_ff @(posedge clk) begin
    if (rst) begin
      ws_prod <= PROD_W'(1);
    end else begin
      ws_prod <= cfg.size * cfg.w;
    end
  end

  logic en;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage 0: input register
  logic             s0_valid, s0_op;
  logic [IDX_W-1:0] s0_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_op  <= opcode;
      s0_idx <= index_in;
    end
  end

  // stage 1: offset from the base
  logic             s1_valid, s1_op;
  logic [IDX_W-1:0] s1_idx;
  logic [OFF_W-1:0] s1_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op  <= s0_op;
      s1_idx <= s0_idx;
      s1_off <= {s0_idx[IDX_W-1], s0_idx} - {global_base[IDX_W-1], global_base};
    end
  end

  // divider operands
  logic [OFF_W-1:0]  o49, n_a, mag_a, mag_b;
  logic [PROD_W-1:0] d_a;
  logic              neg_a, neg_b;
  side_t             side_a, side_q;

  assign o49 = {{(OFF_W-LOC_W){s1_off[LOC_W-1]}}, s1_off[LOC_W-1:0]};

  always_comb begin
    priority if (s1_op == OP_L2G && dist_mode == MODE_BCYCLIC) begin
      n_a = {s1_idx[IDX_W-1], s1_idx};
      d_a = {{(PROD_W-CW_W){1'b0}}, cfg.w};
    end else if (s1_op == OP_G2L && dist_mode == MODE_CYCLIC) begin
      n_a = s1_off;
      d_a = {{(PROD_W-CNT_W){1'b0}}, cfg.size};
    end else if (s1_op == OP_G2L && dist_mode == MODE_BCYCLIC) begin
      n_a = o49;
      d_a = ws_prod;
    end else begin
      n_a = '0;
      d_a = PROD_W'(1);
    end
  end

  assign neg_a = n_a[OFF_W-1];
  assign mag_a = neg_a ? -n_a : n_a;
  assign neg_b = s1_off[LOC_W-1];
  assign mag_b = neg_b ? -o49 : o49;

  assign side_a.opcode = s1_op;
  assign side_a.idx    = s1_idx;
  assign side_a.off    = s1_off;
  assign side_a.neg_a  = neg_a;
  assign side_a.neg_b  = neg_b;

  logic                     dv_a, dv_b;
  logic [OFF_W-1:0]         quo_a, quo_b;
  logic [PROD_W-1:0]        rem_a;
  logic [CW_W-1:0]          rem_b;
  logic [$bits(side_t)-1:0] side_a_out;
  logic                     op_b;

  idxmap_div #(
    .N  (OFF_W),
    .D  (PROD_W),
    .SW ($bits(side_t))
  ) u_div_a (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_valid),
    .num       (mag_a),
    .den       (d_a),
    .side_in   (side_a),
    .out_valid (dv_a),
    .quo       (quo_a),
    .rem       (rem_a),
    .side_out  (side_a_out)
  );

  // remainder by the cycle width for block-cyclic global to local
  idxmap_div #(
    .N  (OFF_W),
    .D  (CW_W),
    .SW (1)
  ) u_div_b (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_valid),
    .num       (mag_b),
    .den       (cfg.w),
    .side_in   (s1_op),
    .out_valid (dv_b),
    .quo       (quo_b),
    .rem       (rem_b),
    .side_out  (op_b)
  );

  assign side_q = side_t'(side_a_out);

  idxmap_post #(
    .GLOBAL_WIDTH (GLOBAL_WIDTH)
  ) u_post (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (dv_a),
    .quo        (quo_a),
    .rem_a      (rem_a),
    .rem_b      (rem_b),
    .side       (side_q),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .index_out  (index_out),
    .mode_error (mode_error)
  );

  `CHK_ALWAYS(a_div_lockstep, clk, rst, dv_a == dv_b)
  `CHK_IMPL(a_div_same_item, clk, rst, dv_a, op_b == side_q.opcode && quo_b[OFF_W-1] == 1'b0)
  `CHK_IMPL(a_err_zero, clk, rst, out_valid && mode_error, index_out == '0)
  `CHK_IMPL(a_bad_mode, clk, rst, out_valid && dist_mode > MODE_GBLOCK, mode_error)

endmodule
